>>> rtl/cfbl_pkg.sv
// ----------------------------------------------------------------------------
// CAN frame bit length: shared package
// Widths, mode codes, per-stage record types and pipeline sizing for the
// frame length pipeline.
// ----------------------------------------------------------------------------
package cfbl_pkg;

   // Message vector: SOF through the last data bit, right aligned.
   // The longest message is an extended data frame of 39 + 64 bits.
   localparam int unsigned ChunkWidth  = 8;
   localparam int unsigned MsgStages   = 13;
   localparam int unsigned MsgWidth    = MsgStages * ChunkWidth;
   localparam int unsigned PosWidth    = $clog2(MsgWidth + 1);

   // CRC-15-CAN and the bits after it.
   localparam int unsigned CrcWidth    = 15;
   localparam logic [CrcWidth-1:0] CrcPoly = 15'h4599;
   localparam int unsigned TailStages  = (CrcWidth + ChunkWidth - 1) / ChunkWidth;
   localparam int unsigned TrailerBits = 13;
   localparam int unsigned NumStages   = MsgStages + TailStages;

   // Header lengths from SOF through the DLC field.
   localparam int unsigned HdrWidth    = 39;
   localparam int unsigned HdrBaseBits = 19;
   localparam int unsigned HdrExtBits  = 39;

   // Closed-form frame lengths without data bytes.
   localparam logic [7:0] PlainBase    = 8'd47;
   localparam logic [7:0] PlainBaseExt = 8'd67;
   localparam logic [7:0] WorstBase    = 8'd55;
   localparam logic [7:0] WorstBaseExt = 8'd80;

   // Longest valid data length code.
   localparam logic [7:0] MaxDlc = 8'd8;

   // Run length that forces a stuff bit.
   localparam logic [2:0] StuffRun = 3'd5;

   typedef enum logic [1:0] {
      FUNC_PLAIN = 2'd0,
      FUNC_WORST = 2'd1,
      FUNC_EXACT = 2'd2,
      FUNC_BAD   = 2'd3
   } func_type;

   // Running CRC and stuff scanner state.
   typedef struct packed {
      logic [CrcWidth-1:0] crc;
      logic                last;
      logic [2:0]          run;
      logic [4:0]          stuff;
   } scan_type;

   // Per-item facts settled at assembly time.
   typedef struct packed {
      logic                err;
      logic                exact;
      logic [7:0]          formula;
      logic [PosWidth-1:0] mlen;
   } meta_type;

   // One item as it moves down the pipeline.
   typedef struct packed {
      logic [MsgWidth-1:0] msg;
      logic [PosWidth-1:0] pad;
      meta_type            meta;
      scan_type            scan;
   } item_type;

endpackage

>>> rtl/cfbl_stage.sv
// ----------------------------------------------------------------------------
// CAN frame bit length: scan stage
// Registered stage that folds one 8-bit chunk of the frame into the CRC and
// the stuff-bit scanner, or feeds a chunk of the finished CRC to the scanner.
// ----------------------------------------------------------------------------
module cfbl_stage #(
   parameter int unsigned Base    = 0,
   parameter bit          CrcTail = 1'b0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   input  cfbl_pkg::item_type up_item,
   output logic               up_ready,
   output logic               dn_valid,
   output cfbl_pkg::item_type dn_item,
   input  logic               dn_ready
);

   logic               valid_ff;
   logic               valid_in;
   cfbl_pkg::item_type item_ff;
   cfbl_pkg::item_type item_in;

   // The stage takes a new transfer when empty or when its content moves on.
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // Fold eight bits, one after another, into the run state, and into the CRC on message chunks.
   always_comb begin
      logic [cfbl_pkg::CrcWidth-1:0] crc;
      logic                          last;
      logic [2:0]                    run;
      logic [4:0]                    stuff;
      logic                          b;
      logic                          act;
      logic                          fb;
      int unsigned                   pos;
      crc   = up_item.scan.crc;
      last  = up_item.scan.last;
      run   = up_item.scan.run;
      stuff = up_item.scan.stuff;
      for (int unsigned j = 0; j < cfbl_pkg::ChunkWidth; j++) begin
         pos = Base + j;
         if (CrcTail) begin
            act = (pos < cfbl_pkg::CrcWidth);
            b   = act ? up_item.scan.crc[act ? cfbl_pkg::CrcWidth - 1 - pos : 0] : 1'b0;
         end else begin
            act = (cfbl_pkg::PosWidth'(pos) >= up_item.pad);
            b   = up_item.msg[cfbl_pkg::MsgWidth - 1 - pos];
            // Pad bits are zero ahead of SOF, so the CRC stays zero over them.
            fb  = b ^ crc[cfbl_pkg::CrcWidth-1];
            crc = {crc[cfbl_pkg::CrcWidth-2:0], 1'b0} ^ (fb ? cfbl_pkg::CrcPoly : '0);
         end
         if (act) begin
            if (run != 3'd0 && b == last) begin
               run = run + 3'd1;
            end else begin
               last = b;
               run  = 3'd1;
            end
            if (run == cfbl_pkg::StuffRun) begin
               stuff = stuff + 5'd1;
               last  = ~last;
               run   = 3'd1;
            end
         end
      end
      item_in            = up_item;
      item_in.scan.crc   = crc;
      item_in.scan.last  = last;
      item_in.scan.run   = run;
      item_in.scan.stuff = stuff;
   end

   // Valid bit with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Item register, loaded on each accepted transfer.
   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         item_ff <= item_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;

endmodule

>>> rtl/can_frame_bit_length.sv
// ----------------------------------------------------------------------------
// CAN frame bit length: top level
// Computes the on-wire length of a classic CAN frame in bits, either from
// closed formulas or exactly, with CRC-15 and bit stuffing.
// ----------------------------------------------------------------------------
// Usage:
// A message descriptor enters on the req_ channel (valid/stall); one result
// (bit_count, error) leaves on the rsp_ channel for every descriptor, in order.
// The pipeline is an assembly register, thirteen chunk stages that fold
// eight message bits each into the CRC and stuff scanner, two stages that
// scan the fifteen CRC bits, and the output register. One descriptor is
// taken every cycle while req_stall is low. Every mode goes through the
// same stages, so order is kept without tags.
// When the receiver stalls, the output register holds its result and stages
// behind it keep filling bubbles; req_stall rises only once every stage is
// occupied. Reset clears all valid bits; no item is in flight afterward.
// An FD frame, a length code above eight or mode 3 returns error with zero
// bit count.
// ----------------------------------------------------------------------------
module can_frame_bit_length (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [28:0] req_ident,
   input  logic        req_extended,
   input  logic        req_remote,
   input  logic        req_fd_frame,
   input  logic [7:0]  req_length,
   input  logic [63:0] req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_bit_count,
   output logic        rsp_error
);

   localparam int unsigned NumStages = cfbl_pkg::NumStages;
   localparam int unsigned MsgW      = cfbl_pkg::MsgWidth;
   localparam int unsigned PosW      = cfbl_pkg::PosWidth;

   // Assembly register.
   logic               ld_valid_ff;
   logic               ld_valid_in;
   cfbl_pkg::item_type ld_item_ff;
   cfbl_pkg::item_type ld_item_in;
   logic               ld_ready;

   // Links between stages.
   logic               link_valid [0:NumStages];
   cfbl_pkg::item_type link_item  [0:NumStages];
   logic               link_ready [0:NumStages];

   // Output register.
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [7:0]         rsp_bit_count_ff;
   logic [7:0]         rsp_bit_count_in;
   logic               rsp_error_ff;
   logic               rsp_error_in;
   logic               out_ready;

   // Assemble the message bits, right aligned, and the closed-form lengths.
   always_comb begin
      logic [cfbl_pkg::HdrWidth-1:0] hdr;
      logic [3:0]                    dlen;
      logic [PosW-1:0]               shamt;
      logic [PosW-1:0]               mlen;
      logic [7:0]                    d8;
      logic                          err;
      err = req_fd_frame || (req_length > cfbl_pkg::MaxDlc) ||
            (cfbl_pkg::func_type'(req_func) == cfbl_pkg::FUNC_BAD);
      dlen = (req_remote || req_length > cfbl_pkg::MaxDlc) ? 4'd0 : req_length[3:0];
      if (req_extended) begin
         hdr = {1'b0, req_ident[28:18], 2'b11, req_ident[17:0], req_remote, 2'b00,
                req_length[3:0]};
      end else begin
         hdr = {20'd0, 1'b0, req_ident[10:0], req_remote, 2'b00, req_length[3:0]};
      end
      shamt = {dlen, 3'b000};
      mlen  = (req_extended ? PosW'(cfbl_pkg::HdrExtBits) : PosW'(cfbl_pkg::HdrBaseBits))
              + shamt;
      ld_item_in.msg = (MsgW'(hdr) << shamt) | (MsgW'(req_payload) >> (PosW'(64) - shamt));
      ld_item_in.pad = PosW'(MsgW) - mlen;

      d8 = {4'd0, dlen};
      ld_item_in.meta.err   = err;
      ld_item_in.meta.exact = (cfbl_pkg::func_type'(req_func) == cfbl_pkg::FUNC_EXACT);
      ld_item_in.meta.mlen  = mlen;
      if (cfbl_pkg::func_type'(req_func) == cfbl_pkg::FUNC_WORST) begin
         ld_item_in.meta.formula = (req_extended ? cfbl_pkg::WorstBaseExt : cfbl_pkg::WorstBase)
                                   + (d8 << 3) + (d8 << 1);
      end else begin
         ld_item_in.meta.formula = (req_extended ? cfbl_pkg::PlainBaseExt : cfbl_pkg::PlainBase)
                                   + (d8 << 3);
      end
      ld_item_in.scan = '0;
   end

   // Input handshake on the assembly register.
   assign ld_ready    = !ld_valid_ff || link_ready[0];
   assign req_stall   = !ld_ready;
   assign ld_valid_in = ld_ready ? req_valid : ld_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ld_valid_ff <= 1'b0;
      end else begin
         ld_valid_ff <= ld_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_ready && req_valid) begin
         ld_item_ff <= ld_item_in;
      end
   end

   assign link_valid[0] = ld_valid_ff;
   assign link_item[0]  = ld_item_ff;

   // Chunk stages over the message, then over the CRC.
   for (genvar g = 0; g < NumStages; g++) begin : g_stage
      localparam bit          Tail = (g >= cfbl_pkg::MsgStages);
      localparam int unsigned Off  = Tail ? (g - cfbl_pkg::MsgStages) * cfbl_pkg::ChunkWidth
                                          : g * cfbl_pkg::ChunkWidth;
      cfbl_stage #(
         .Base    (Off),
         .CrcTail (Tail)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (link_valid[g]),
         .up_item  (link_item[g]),
         .up_ready (link_ready[g]),
         .dn_valid (link_valid[g+1]),
         .dn_item  (link_item[g+1]),
         .dn_ready (link_ready[g+1])
      );
   end

   // Result: exact sum of message bits, CRC, stuff bits and trailer, or the closed form, or zero on error.
   assign out_ready             = !rsp_valid_ff || !rsp_stall;
   assign link_ready[NumStages] = out_ready;
   assign rsp_valid_in          = out_ready ? link_valid[NumStages] : rsp_valid_ff;

   always_comb begin
      logic [7:0] total;
      total = 8'(link_item[NumStages].meta.mlen) + 8'(link_item[NumStages].scan.stuff)
              + 8'(cfbl_pkg::CrcWidth + cfbl_pkg::TrailerBits);
      rsp_error_in = link_item[NumStages].meta.err;
      if (link_item[NumStages].meta.err) begin
         rsp_bit_count_in = 8'd0;
      end else if (link_item[NumStages].meta.exact) begin
         rsp_bit_count_in = total;
      end else begin
         rsp_bit_count_in = link_item[NumStages].meta.formula;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && link_valid[NumStages]) begin
         rsp_bit_count_ff <= rsp_bit_count_in;
         rsp_error_ff     <= rsp_error_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bit_count = rsp_bit_count_ff;
   assign rsp_error     = rsp_error_ff;

   // An error result always carries a zero count.
   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_bit_count == 8'd0)
      else $error("error result with nonzero bit count");

   // Any good frame lies between the shortest and longest possible lengths.
   a_len_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_error |-> rsp_bit_count >= 8'd47 && rsp_bit_count <= 8'd160)
      else $error("frame length out of range");

   // Input backpressure only arises from a stalled, occupied output register.
   a_stall_src : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   // A result held under stall is still there at the next edge.
   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bit_count))
      else $error("stalled result lost");

endmodule
